// ===== hw/rtl/rampc_pkg.sv =====
// Shared types, constants and helper functions of the motor ramp controller.
// Used by every module under hw/rtl except rampc_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rampc_pkg;

  // Sizing
  localparam int CHANNELS  = 5;
  localparam int TABLE_LEN = 100;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAB_AW    = $clog2(TABLE_LEN);
  localparam int LB_W      = $clog2(2 * CHANNELS);
  localparam int LIMIT_W   = 10;
  localparam int SPD_W     = 10;
  localparam int TICK_W    = 10;
  localparam int RT_W      = 16;
  localparam int QDEPTH    = 2;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  // run_time / 100 as a multiply by 2^24/100 rounded up, exact for 16-bit inputs
  localparam int DIV100_MUL   = 167773;
  localparam int DIV100_SHIFT = 24;
  localparam int PROD_W       = RT_W + 18;

  // Register reset values
  localparam logic [SPD_W-1:0] SPEED_OFFSET_RST = SPD_W'(0);
  localparam logic [RT_W-1:0]  MIN_RUN_RST      = RT_W'(1000);
  localparam logic             BACK_DIR_RST     = 1'b1;
  localparam logic             LIMIT_LVL_RST    = 1'b0;
  localparam logic [SPD_W-1:0] MAX_SPEED_RST    = SPD_W'(1000);

  // Operation codes of the input word
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_LIMIT   = 3'd1,
    OP_START   = 3'd2,
    OP_REVERSE = 3'd3,
    OP_STOP    = 3'd4,
    OP_TWRITE  = 3'd5,
    OP_QUERY   = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [2:0]         motor;
    logic               direction;
    logic [RT_W-1:0]    run_time;
    logic [LIMIT_W-1:0] limit_bits;
    logic [6:0]         table_index;
    logic [SPD_W-1:0]   table_value;
  } in_t;

  typedef struct packed {
    logic [2:0]       channel;
    logic [SPD_W-1:0] speed_cmd;
    logic             dir_out;
    logic             running;
    logic             ramp_active;
    logic             accepted;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [SPD_W-1:0] speed_offset;
    logic [RT_W-1:0]  min_run_time;
    logic             backward_dir;
    logic             limit_level;
    logic [SPD_W-1:0] max_speed;
  } cfg_t;

  // Classified command handed from the front end to the sequencer
  typedef struct packed {
    op_e                op;
    logic [CH_W-1:0]    ch;
    logic               dir;
    logic               start_ok;
    logic [TICK_W-1:0]  interval;
    logic [LIMIT_W-1:0] limits;
    logic               twr_en;
    logic [TAB_AW-1:0]  taddr;
    logic [SPD_W-1:0]   tval;
  } cmd_t;

  // Channel number modulo CHANNELS by repeated subtraction (3-bit input)
  function automatic logic [CH_W-1:0] mod_channels(input logic [2:0] m);
    logic [4:0] v;
    v = {2'b00, m};
    for (int k = 0; k < 8; k++) begin
      if (v >= 5'(CHANNELS)) v = v - 5'(CHANNELS);
    end
    return CH_W'(v);
  endfunction

  // Power-up contents of the speed profile
  function automatic logic [SPD_W-1:0] tab_reset(input logic [TAB_AW-1:0] a);
    int unsigned ai;
    logic [SPD_W-1:0] r;
    ai = 32'(a);
    case (ai)
      0:       r = SPD_W'(600);
      1:       r = SPD_W'(620);
      2:       r = SPD_W'(640);
      3:       r = SPD_W'(660);
      4:       r = SPD_W'(680);
      96:      r = SPD_W'(680);
      97:      r = SPD_W'(660);
      98:      r = SPD_W'(640);
      99:      r = SPD_W'(620);
      default: r = SPD_W'(700);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rampc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rampc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rampc_regs.sv =====
// APB-style configuration registers of the motor ramp controller.
// Depends on rampc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rampc_regs
  import rampc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  typedef enum logic [2:0] {
    REG_SPEED_OFFSET = 3'd0,
    REG_MIN_RUN_TIME = 3'd1,
    REG_BACKWARD_DIR = 3'd2,
    REG_LIMIT_LEVEL  = 3'd3,
    REG_MAX_SPEED    = 3'd4
  } reg_e;

  cfg_t            cfg_q;
  logic            wr_en;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_offset <= SPEED_OFFSET_RST;
      cfg_q.min_run_time <= MIN_RUN_RST;
      cfg_q.backward_dir <= BACK_DIR_RST;
      cfg_q.limit_level  <= LIMIT_LVL_RST;
      cfg_q.max_speed    <= MAX_SPEED_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SPEED_OFFSET: cfg_q.speed_offset <= pwdata[SPD_W-1:0];
        REG_MIN_RUN_TIME: cfg_q.min_run_time <= pwdata[RT_W-1:0];
        REG_BACKWARD_DIR: cfg_q.backward_dir <= pwdata[0];
        REG_LIMIT_LEVEL:  cfg_q.limit_level  <= pwdata[0];
        REG_MAX_SPEED:    cfg_q.max_speed    <= pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_SPEED_OFFSET: prdata = PDATA_W'(cfg_q.speed_offset);
      REG_MIN_RUN_TIME: prdata = PDATA_W'(cfg_q.min_run_time);
      REG_BACKWARD_DIR: prdata = PDATA_W'(cfg_q.backward_dir);
      REG_LIMIT_LEVEL:  prdata = PDATA_W'(cfg_q.limit_level);
      REG_MAX_SPEED:    prdata = PDATA_W'(cfg_q.max_speed);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rampc_front.sv =====
// Front end: accepts input words, decodes and classifies them into commands.
// Depends on rampc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rampc_front
  import rampc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_word_i,
  output logic      push_valid_o,
  input  wire logic push_ready_i,
  output cmd_t      push_cmd_o
);

  logic              fe_valid_q;
  cmd_t              fe_cmd_q;
  cmd_t              fe_cmd_d;
  logic [PROD_W-1:0] prod;
  logic              in_fire;

  assign in_ready_o = !fe_valid_q || push_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Step interval = run_time / 100 by reciprocal multiply
  assign prod = PROD_W'(in_word_i.run_time) * PROD_W'(DIV100_MUL);

  // Decode
  always_comb begin
    case (in_word_i.opcode)
      OP_TICK:    fe_cmd_d.op = OP_TICK;
      OP_LIMIT:   fe_cmd_d.op = OP_LIMIT;
      OP_START:   fe_cmd_d.op = OP_START;
      OP_REVERSE: fe_cmd_d.op = OP_REVERSE;
      OP_STOP:    fe_cmd_d.op = OP_STOP;
      OP_TWRITE:  fe_cmd_d.op = OP_TWRITE;
      default:    fe_cmd_d.op = OP_QUERY;
    endcase
    fe_cmd_d.ch       = mod_channels(in_word_i.motor);
    fe_cmd_d.dir      = in_word_i.direction;
    fe_cmd_d.start_ok = in_word_i.run_time >= cfg_i.min_run_time;
    fe_cmd_d.interval = prod[DIV100_SHIFT +: TICK_W];
    fe_cmd_d.limits   = in_word_i.limit_bits;
    fe_cmd_d.twr_en   = {1'b0, in_word_i.table_index} < 8'(TABLE_LEN);
    fe_cmd_d.taddr    = in_word_i.table_index[TAB_AW-1:0];
    fe_cmd_d.tval     = in_word_i.table_value;
  end

  // Front stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_valid_q <= 1'b0;
    end else if (in_fire) begin
      fe_valid_q <= 1'b1;
    end else if (push_ready_i) begin
      fe_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) fe_cmd_q <= fe_cmd_d;
  end

  assign push_valid_o = fe_valid_q;
  assign push_cmd_o   = fe_cmd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rampc_queue.sv =====
// Short command queue between the front end and the sequencer.
// Depends on rampc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rampc_queue
  import rampc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_cmd_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_cmd_o
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = count_q != CNT_W'(QDEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rampc_back.sv =====
// Sequencer: holds per-channel ramp state and the profile table, carries out
// commands channel by channel and drives the result register.
// Depends on rampc_pkg and rampc_ram.
`timescale 1ns / 1ps
`default_nettype none

module rampc_back
  import rampc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic pop_valid_i,
  output logic      pop_ready_o,
  input  wire cmd_t pop_cmd_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_word_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } state_e;

  state_e          state_q;
  cmd_t            cmd_q;
  logic [CH_W-1:0] ch_q;
  logic            out_valid_q;
  out_t            out_word_q;

  // Per-channel ramp state
  logic              ramp_on_q  [CHANNELS];
  logic              move_dir_q [CHANNELS];
  logic [TICK_W-1:0] tick_q     [CHANNELS];
  logic [TICK_W-1:0] intv_q     [CHANNELS];
  logic [TAB_AW-1:0] pos_q      [CHANNELS];
  logic              rev_q      [CHANNELS];
  logic              run_q      [CHANNELS];
  logic [SPD_W-1:0]  spd_q      [CHANNELS];

  // Profile entries written since reset
  logic              tvalid_q [TABLE_LEN];
  logic              tv_q;
  logic [TAB_AW-1:0] ra_q;

  logic              r_on, r_dir, r_rev, r_run;
  logic [TICK_W-1:0] r_tick, r_intv;
  logic [TAB_AW-1:0] r_pos;
  logic [SPD_W-1:0]  r_spd;

  logic              n_on, n_dir, n_rev, n_run;
  logic [TICK_W-1:0] n_tick, n_intv;
  logic [TAB_AW-1:0] n_pos;
  logic [SPD_W-1:0]  n_spd;
  logic              acc;

  logic [TAB_AW:0]   fwd_pos;
  logic [TAB_AW-1:0] back_pos;
  logic              fwd_end;
  logic [TAB_AW-1:0] rd_addr;
  logic [SPD_W-1:0]  ram_rdata;
  logic [SPD_W-1:0]  tab_val;
  logic [SPD_W:0]    tab_plus_off;
  logic [TICK_W:0]   tick_inc;
  logic [LB_W-1:0]   lbit;
  logic [LIMIT_W-1:0] lim_sh;
  logic              lim_hit;
  logic              cmd_req, cmd_dir;
  logic [SPD_W:0]    cmd_spd;
  logic              is_multi, is_last;
  logic              exec_fire;
  logic              tab_we;
  out_t              res;

  // Current channel view
  assign r_on   = ramp_on_q[ch_q];
  assign r_dir  = move_dir_q[ch_q];
  assign r_tick = tick_q[ch_q];
  assign r_intv = intv_q[ch_q];
  assign r_pos  = pos_q[ch_q];
  assign r_rev  = rev_q[ch_q];
  assign r_run  = run_q[ch_q];
  assign r_spd  = spd_q[ch_q];

  // Neighbor profile positions and the table address for this step
  assign fwd_pos  = {1'b0, r_pos} + (TAB_AW + 1)'(1);
  assign back_pos = (r_pos != '0) ? r_pos - TAB_AW'(1) : '0;
  assign fwd_end  = fwd_pos > (TAB_AW + 1)'(TABLE_LEN - 1);

  always_comb begin
    case (cmd_q.op)
      OP_TICK:    rd_addr = r_rev ? back_pos : (fwd_end ? '0 : fwd_pos[TAB_AW-1:0]);
      OP_REVERSE: rd_addr = r_pos;
      default:    rd_addr = '0;
    endcase
  end

  // Profile table
  assign tab_we = exec_fire && (cmd_q.op == OP_TWRITE) && cmd_q.twr_en;

  rampc_ram #(
    .WIDTH (SPD_W),
    .DEPTH (TABLE_LEN)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (cmd_q.taddr),
    .wdata_i (cmd_q.tval),
    .re_i    (state_q == ST_FETCH),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TABLE_LEN; k++) tvalid_q[k] <= 1'b0;
    end else if (tab_we) begin
      tvalid_q[cmd_q.taddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FETCH) begin
      tv_q <= tvalid_q[rd_addr];
      ra_q <= rd_addr;
    end
  end

  assign tab_val      = tv_q ? ram_rdata : tab_reset(ra_q);
  assign tab_plus_off = {1'b0, tab_val} + {1'b0, cfg_i.speed_offset};
  assign tick_inc     = {1'b0, r_tick} + (TICK_W + 1)'(1);

  // Limit switch bit for this channel in its direction of travel
  assign lbit    = (r_dir == cfg_i.backward_dir) ? LB_W'(ch_q)
                                                 : LB_W'(32'(CHANNELS) + 32'(ch_q));
  assign lim_sh  = cmd_q.limits >> lbit;
  assign lim_hit = (32'(lbit) < 32'(LIMIT_W)) && (lim_sh[0] == cfg_i.limit_level);

  // Next state of the current channel
  always_comb begin
    n_on    = r_on;
    n_dir   = r_dir;
    n_tick  = r_tick;
    n_intv  = r_intv;
    n_pos   = r_pos;
    n_rev   = r_rev;
    n_run   = r_run;
    n_spd   = r_spd;
    acc     = 1'b0;
    cmd_req = 1'b0;
    cmd_dir = r_dir;
    cmd_spd = {1'b0, tab_val};

    case (cmd_q.op)
      OP_TICK: begin
        if (r_on) begin
          if (tick_inc > {1'b0, r_intv}) begin
            n_tick = '0;
            if ((!r_rev && fwd_end) || (r_rev && back_pos == '0)) begin
              // ramp runs off the table: stop stepping, keep speed
              n_on   = 1'b0;
              n_pos  = '0;
              n_intv = '0;
              n_rev  = 1'b1;
            end else begin
              n_pos   = r_rev ? back_pos : fwd_pos[TAB_AW-1:0];
              cmd_req = 1'b1;
              cmd_spd = tab_plus_off;
            end
          end else begin
            n_tick = tick_inc[TICK_W-1:0];
          end
        end
      end
      OP_LIMIT: begin
        if (r_run && lim_hit) begin
          n_spd  = '0;
          n_run  = 1'b0;
          n_on   = 1'b0;
          n_tick = '0;
          n_pos  = '0;
          n_intv = '0;
          n_rev  = 1'b1;
        end
      end
      OP_START: begin
        if (cmd_q.start_ok) begin
          n_on    = 1'b1;
          n_tick  = '0;
          n_pos   = '0;
          n_intv  = cmd_q.interval;
          n_dir   = cmd_q.dir;
          n_rev   = !r_rev;
          n_run   = 1'b1;
          cmd_req = 1'b1;
          cmd_dir = cmd_q.dir;
          acc     = 1'b1;
        end
      end
      OP_REVERSE: begin
        if (r_on && r_run && r_pos != '0) begin
          n_rev   = !r_rev;
          n_dir   = !r_dir;
          cmd_req = 1'b1;
          cmd_dir = !r_dir;
          acc     = 1'b1;
        end
      end
      OP_STOP: begin
        n_spd  = '0;
        n_run  = 1'b0;
        n_on   = 1'b0;
        n_tick = '0;
        n_pos  = '0;
        n_intv = '0;
        n_rev  = 1'b1;
      end
      default: ;
    endcase

    // Speed command, dropped entirely above max_speed
    if (cmd_req && cmd_spd <= {1'b0, cfg_i.max_speed}) begin
      n_dir = cmd_dir;
      n_spd = cmd_spd[SPD_W-1:0];
      if (cmd_spd != '0) n_run = 1'b1;
    end
  end

  assign is_multi  = (cmd_q.op == OP_TICK) || (cmd_q.op == OP_LIMIT);
  assign is_last   = !is_multi || (ch_q == CH_W'(CHANNELS - 1));
  assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    res.channel     = 3'(ch_q);
    res.speed_cmd   = n_spd;
    res.dir_out     = n_dir;
    res.running     = n_run;
    res.ramp_active = n_on;
    res.accepted    = acc;
    res.last        = is_last;
  end

  // Channel state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CHANNELS; k++) begin
        ramp_on_q[k]  <= 1'b0;
        move_dir_q[k] <= 1'b0;
        tick_q[k]     <= '0;
        intv_q[k]     <= '0;
        pos_q[k]      <= '0;
        rev_q[k]      <= 1'b1;
        run_q[k]      <= 1'b0;
        spd_q[k]      <= '0;
      end
    end else if (exec_fire) begin
      ramp_on_q[ch_q]  <= n_on;
      move_dir_q[ch_q] <= n_dir;
      tick_q[ch_q]     <= n_tick;
      intv_q[ch_q]     <= n_intv;
      pos_q[ch_q]      <= n_pos;
      rev_q[ch_q]      <= n_rev;
      run_q[ch_q]      <= n_run;
      spd_q[ch_q]      <= n_spd;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            cmd_q   <= pop_cmd_i;
            ch_q    <= (pop_cmd_i.op == OP_TICK || pop_cmd_i.op == OP_LIMIT) ? '0
                                                                             : pop_cmd_i.ch;
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec_fire) begin
            out_valid_q <= 1'b1;
            out_word_q  <= res;
            if (is_last) begin
              state_q <= ST_IDLE;
            end else begin
              ch_q    <= ch_q + CH_W'(1);
              state_q <= ST_FETCH;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign pop_ready_o = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/multi_motor_ramp_profile_controller.sv =====
// Five-channel table-driven motor speed ramp controller.
// Input word: an operation (tick, limit sample, start, reverse, stop, profile
// write, status query) on the in_* valid/ready channel. Results leave on the
// out_* valid/ready channel: tick and limit sample give one word per channel
// in channel order, every other operation one word for the addressed channel;
// the final word of an operation has last set.
// The first result of an input word is registered once the word has passed the
// front stage register, the queue, the sequencer pick-up, fetch and execute.
// For each channel the sequencer reads the profile table (fetch), then updates
// the channel (execute); a tick or limit sample walks all five channels, other
// operations only one, and the next command is picked up only after the last.
// A two-entry command queue sits between decode and the sequencer, so input
// words keep being taken while results wait. When the receiver stalls, the
// result register holds and the sequencer waits; the queue and front stage
// fill and then in_ready_o drops.
// Reset: all channels stopped with ramps cleared, registers at their defaults
// and the profile table at its power-up contents; no clearing pass is needed.
// Configuration goes through the APB port (pready always high).
// Depends on rampc_pkg, rampc_regs, rampc_front, rampc_queue, rampc_back.
`timescale 1ns / 1ps
`default_nettype none

module multi_motor_ramp_profile_controller
  import rampc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_t                in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_t                    out_word_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t cfg;
  logic fe_push_valid, q_push_ready;
  cmd_t fe_cmd;
  logic q_pop_valid, q_pop_ready;
  cmd_t q_cmd;

  rampc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rampc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .push_valid_o (fe_push_valid),
    .push_ready_i (q_push_ready),
    .push_cmd_o   (fe_cmd)
  );

  rampc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_push_valid),
    .push_ready_o (q_push_ready),
    .push_cmd_i   (fe_cmd),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_cmd_o    (q_cmd)
  );

  rampc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_cmd_i   (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // Input stalls only because the queue is full behind a loaded front stage
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (fe_push_valid && !q_push_ready))
    else $error("input stalled without downstream backpressure");

  // The sequencer takes one command and is not ready for another in the cycle after
  a_single_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_valid && q_pop_ready) |=> !q_pop_ready)
    else $error("sequencer popped two commands back to back");

  // Only the channel walk produces words without last, and never past the end
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.last) |-> (32'(out_word_o.channel) < CHANNELS - 1))
    else $error("non-final result word from an out-of-range channel");

endmodule

`default_nettype wire
